>>> hdl/sgm_pkg.sv
// Package for the Sobel gradient magnitude block.
// Holds the register indexes, arithmetic constants and the controller/datapath types.
// No dependencies.
package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 16;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 16;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd1024;

  // |gx|,|gy| <= 1020; sum of squares < 2^21; root < 2^11
  localparam int ABS_W  = 10;
  localparam int SQ_W   = 20;
  localparam int SUM_W  = 21;
  localparam int REM_W  = 22;
  localparam int ROOT_W = 11;

  localparam int        ROOT_STEPS = 11;
  localparam int        STEP_W     = 4;

  // floor(x/3) == (x*683) >> 11 for x < 2048
  localparam logic [9:0] RECIP3     = 10'd683;
  localparam int         RECIP3_SH  = 11;
  localparam int         PROD_W     = 21;

  typedef struct packed {
    logic capture;
    logic process;
    logic square;
    logic sum_init;
    logic root_step;
    logic scale;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
  } dp_status_t;

endpackage

>>> hdl/sgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sgm_ctrl.sv
// Sequencer for the Sobel gradient magnitude block.
// Steps one item through read, square, root and scale; owns the output valid flag.
// Depends on sgm_pkg.
module sgm_ctrl
  import sgm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_SCALE,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.process = 1'b1;
        state_d       = status_i.interior ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_init = 1'b1;
        step_d         = '0;
        state_d        = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/sgm_datapath.sv
// Datapath of the Sobel gradient magnitude block: size registers, counters,
// line stores, 3x3 window, gradient, iterative square root and scaling.
// Depends on sgm_pkg and sgm_ram.
module sgm_datapath
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [PIX_W-1:0]   pixel_value_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic [PIX_W-1:0]   edge_value_o,
  output logic               frame_last_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > IMG_W_W) ? WW : IMG_W_W;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [CW-1:0]      w_ext, w_clamp;
  logic [WW-1:0]      eff_w;
  logic [IMG_H_W-1:0] eff_h;

  always_comb begin
    w_ext = CW'(width_q);
    if (w_ext < CW'(3)) begin
      w_clamp = CW'(3);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    eff_w = WW'(w_clamp);
    eff_h = (height_q < IMG_H_W'(3)) ? IMG_H_W'(3) : height_q;
  end

  // Position counters; a pixel past the current size starts a new row or frame
  logic [COL_W-1:0]   col_q, col_c_q, col_pre;
  logic [IMG_H_W-1:0] row_q, row_c_q, row_pre;
  logic [IMG_H_W:0]   row_t;
  logic               col_over;

  always_comb begin
    col_over = (WW'(col_q) >= eff_w);
    col_pre  = col_over ? '0 : col_q;
    row_t    = col_over ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
    row_pre  = (row_t >= {1'b0, eff_h}) ? '0 : row_t[IMG_H_W-1:0];
  end

  logic [WW-1:0]      col_inc;
  logic [IMG_H_W:0]   row_inc;
  logic [COL_W-1:0]   col_next;
  logic [IMG_H_W-1:0] row_next;
  logic               interior, last;

  always_comb begin
    col_inc = WW'(col_c_q) + WW'(1);
    row_inc = {1'b0, row_c_q} + 17'd1;
    if (col_inc >= eff_w) begin
      col_next = '0;
      row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[IMG_H_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_c_q;
    end
    interior = (row_c_q >= IMG_H_W'(2)) && (WW'(col_c_q) >= WW'(2));
    last     = (row_c_q == eff_h - IMG_H_W'(1)) && (WW'(col_c_q) == eff_w - WW'(1));
  end

  assign status_o.interior = interior;

  logic [PIX_W-1:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.process) begin
      col_q <= col_next;
      row_q <= row_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pixel_q <= pixel_value_i;
      col_c_q <= col_pre;
      row_c_q <= row_pre;
    end
  end

  // Line stores
  logic [PIX_W-1:0] up_rd, mid_rd;

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.process),
    .waddr_i (col_c_q),
    .wdata_i (mid_rd),
    .re_i    (cmd_i.capture),
    .raddr_i (col_pre),
    .rdata_o (up_rd)
  );

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.process),
    .waddr_i (col_c_q),
    .wdata_i (pixel_q),
    .re_i    (cmd_i.capture),
    .raddr_i (col_pre),
    .rdata_o (mid_rd)
  );

  // Window: [0..2] column c-2, [3..5] column c-1, top to bottom
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.process) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= pixel_q;
    end
  end

  // Gradients
  logic [ABS_W-1:0]   sx_top, sx_bot, sy_lft, sy_rgt;
  logic [ABS_W-1:0]   gx_abs, gy_abs;
  logic [ABS_W-1:0]   gx_abs_q, gy_abs_q;

  always_comb begin
    sx_top = ABS_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + ABS_W'(up_rd);
    sx_bot = ABS_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + ABS_W'(pixel_q);
    sy_lft = ABS_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + ABS_W'(win_q[2]);
    sy_rgt = ABS_W'(up_rd) + {1'b0, mid_rd, 1'b0} + ABS_W'(pixel_q);
    gx_abs = (sx_top >= sx_bot) ? (sx_top - sx_bot) : (sx_bot - sx_top);
    gy_abs = (sy_lft >= sy_rgt) ? (sy_lft - sy_rgt) : (sy_rgt - sy_lft);
  end

  logic last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.process) begin
      gx_abs_q <= gx_abs;
      gy_abs_q <= gy_abs;
      last_q   <= last;
    end
  end

  // Squares
  logic [SQ_W-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqx_q <= SQ_W'(gx_abs_q) * SQ_W'(gx_abs_q);
      sqy_q <= SQ_W'(gy_abs_q) * SQ_W'(gy_abs_q);
    end
  end

  // Integer square root, one result bit per cycle
  logic [REM_W-1:0] rem_q, root_q, bit_q;
  logic [REM_W-1:0] trial;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      rem_q  <= REM_W'(SUM_W'(sqx_q) + SUM_W'(sqy_q));
      root_q <= '0;
      bit_q  <= REM_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Divide by three and saturate
  logic [PROD_W-1:0] prod;
  logic [9:0]        quot;
  logic [PIX_W-1:0]  res_q;

  assign prod = PROD_W'(root_q[ROOT_W-1:0]) * PROD_W'(RECIP3);
  assign quot = prod[RECIP3_SH +: 10];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      res_q <= (quot > 10'd255) ? 8'hFF : quot[PIX_W-1:0];
    end
  end

  // Output register
  logic [PIX_W-1:0] edge_q;
  logic             flast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      edge_q  <= res_q;
      flast_q <= last_q;
    end
  end

  assign edge_value_o = edge_q;
  assign frame_last_o = flast_q;

endmodule

>>> hdl/sobel_gradient_magnitude.sv
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Joins the sequencer and the datapath.
// Depends on sgm_pkg, sgm_ctrl, sgm_datapath.
//
// Usage:
//   Grey pixels enter on the in_* channel in raster order, one item per
//   handshake. Every interior pixel yields one edge value on the out_*
//   channel, in raster order; border pixels yield nothing. frame_last_o
//   marks the final result of a frame.
//   Frame size is set through cfg_we_i/cfg_index_i/cfg_data_i while idle.
//   A border pixel ends after the read state; an interior pixel goes on
//   through square, sum, root, scale and emit states, the square root unit
//   resolving one result bit per cycle; in_ready_o is high only in idle.
//   The output register holds one result; a new pixel is taken while it
//   waits, and only the hand-over of the next result waits on out_ready_i.
//   Reset sets width and height to 1024, clears counters and the window.
//   Line stores are not cleared; they are written before they are used.
module sobel_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] edge_value_o,
  output logic             frame_last_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  sgm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_value_i (pixel_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .edge_value_o  (edge_value_o),
    .frame_last_o  (frame_last_o)
  );

endmodule
